// File: sv/dss_pkg.sv
// Shared types and constants of the dispatcher signature scanner.
// Used by the window cells, the hit-table cells and the top level; no dependencies.
`default_nettype none

package dss_pkg;

  localparam int WIN_LEN   = 12;
  localparam int SIG_LEN   = 13;
  localparam int ADDR_W    = 22;
  localparam int SIZE_W    = 24;
  localparam int POS_W     = 23;
  localparam int CNT_OUT_W = 7;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 24'd2097152;

  // Signature bytes per window offset; offsets without care are don't-care.
  localparam logic [7:0] SIG_BYTE [SIG_LEN] = '{
    8'h3D, 8'h4F, 8'h06, 8'h00, 8'h21, 8'h00, 8'h00,
    8'h09, 8'h09, 8'hC1, 8'h3E, 8'h00, 8'hCD
  };
  // Bit j set: offset j must match. Offsets 5, 6 (pointer) and 11 (bank) are free.
  localparam logic [SIG_LEN-1:0] SIG_CARE = 13'b1_0111_1001_1111;

  // Pointer high byte must be 0x40..0x7F, i.e. its top two bits are 01.
  localparam logic [1:0] PTR_PAGE = 2'b01;
  localparam logic [SIZE_W-1:0] FLAT_GUARD = 24'd4;

  localparam logic KIND_HIT     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef logic [7:0] byte_t;

  // Control handed to every cell of a chain.
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic                 kind;
    logic [ADDR_W-1:0]    addr;
    byte_t                bank;
    logic [CNT_OUT_W-1:0] count;
    logic                 ovf;
  } res_t;

endpackage

`default_nettype wire

// File: sv/dss_win_cell.sv
// One byte cell of the sliding window chain with its signature compare.
// Depends on dss_pkg.
`default_nettype none

module dss_win_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dss_pkg::cell_ctl_t ctl,
  input  wire dss_pkg::byte_t     d_in,
  input  wire dss_pkg::byte_t     exp_byte,
  input  wire logic               care,
  output dss_pkg::byte_t          q,
  output logic                    ok
);

  dss_pkg::byte_t byte_r;
  dss_pkg::byte_t byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clear) begin
      byte_nxt = '0;
    end else if (ctl.shift) begin
      byte_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign q  = byte_r;
  assign ok = !care || (byte_r == exp_byte);

endmodule

`default_nettype wire

// File: sv/dss_hit_cell.sv
// One entry cell of the distinct-hit table chain: holds an address and a valid bit,
// takes its neighbor's entry on an insert and compares against the probe. Depends on dss_pkg.
`default_nettype none

module dss_hit_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire dss_pkg::cell_ctl_t        ctl,
  input  wire logic                      v_in,
  input  wire logic [dss_pkg::ADDR_W-1:0] a_in,
  input  wire logic [dss_pkg::ADDR_W-1:0] probe,
  output logic                           v_out,
  output logic [dss_pkg::ADDR_W-1:0]     a_out,
  output logic                           match
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [dss_pkg::ADDR_W-1:0] addr_r;
  logic [dss_pkg::ADDR_W-1:0] addr_nxt;

  always_comb begin
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      valid_nxt = v_in;
      addr_nxt  = a_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

  assign v_out = valid_r;
  assign a_out = addr_r;
  assign match = valid_r && (addr_r == probe);

endmodule

`default_nettype wire

// File: sv/dispatcher_signature_scanner.sv
// A result is registered in the output buffer on the transfer of the byte that causes it.
// Throughput: one byte per cycle while the skid is empty; the window compare and the parallel
// hit-table cells finish in the cycle of the transfer, and a two-entry output buffer
// keeps the input open while one result waits. Synchronous active-low reset clears the
// window, position, hit table, counters and output buffer and loads image_size with 2097152.
// No clearing pass: the block takes bytes as soon as reset is released.
`default_nettype none

module dispatcher_signature_scanner #(
  parameter int HIT_TABLE_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: image_size.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] cfg_data,
  // Input stream. tdata: [7:0] data_byte.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: [21:0] table_address, [29:22] table_bank, [36:30] hit_count,
  //        [37] table_overflow, [39:38] zero.
  output logic [39:0]      out_tdata,
  // tuser: [0] result_kind.
  output logic             out_tuser
);

  localparam int CNT_W = $clog2(HIT_TABLE_DEPTH + 1);
  localparam int AW    = dss_pkg::ADDR_W;

  // ---------------------------------------------------------------------------
  // Configuration register. Writes are taken at any time and act at once.
  // ---------------------------------------------------------------------------
  logic [dss_pkg::SIZE_W-1:0] size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= dss_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Position counter and end-of-image detection.
  // ---------------------------------------------------------------------------
  logic                      in_fire;
  logic [dss_pkg::POS_W-1:0] pos_r;
  logic [dss_pkg::POS_W-1:0] pos_nxt;
  logic [dss_pkg::SIZE_W-1:0] pos_plus1;
  logic                      last_byte;
  logic                      scan_zone;

  assign in_fire   = in_tvalid && in_tready;
  assign pos_plus1 = {1'b0, pos_r} + 24'd1;
  assign last_byte = (pos_plus1 == size_r);
  // A full window exists from position 12 on, and it must start below size - 13.
  assign scan_zone = (pos_r >= 23'(dss_pkg::WIN_LEN)) && (pos_plus1 < size_r);

  always_comb begin
    pos_nxt = pos_r;
    if (in_fire) begin
      pos_nxt = last_byte ? '0 : pos_plus1[dss_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Window chain: cell j holds window offset j, the newest byte enters cell 11.
  // The current input byte forms offset 12 and is compared here.
  // ---------------------------------------------------------------------------
  dss_pkg::cell_ctl_t win_ctl;
  dss_pkg::byte_t     win_q  [dss_pkg::WIN_LEN];
  dss_pkg::byte_t     win_d  [dss_pkg::WIN_LEN];
  logic [dss_pkg::WIN_LEN-1:0] win_ok;
  logic               sig_ok;

  assign win_ctl.clear = in_fire && last_byte;
  assign win_ctl.shift = in_fire && !last_byte;

  for (genvar j = 0; j < dss_pkg::WIN_LEN; j++) begin : g_win
    if (j == dss_pkg::WIN_LEN - 1) begin : g_head
      assign win_d[j] = in_tdata;
    end else begin : g_body
      assign win_d[j] = win_q[j+1];
    end
    dss_win_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (win_ctl),
      .d_in     (win_d[j]),
      .exp_byte (dss_pkg::SIG_BYTE[j]),
      .care     (dss_pkg::SIG_CARE[j]),
      .q        (win_q[j]),
      .ok       (win_ok[j])
    );
  end

  assign sig_ok = (&win_ok) &&
                  (in_tdata == dss_pkg::SIG_BYTE[dss_pkg::SIG_LEN-1]);

  // Pointer is offsets 5 (low) and 6 (high), bank is offset 11. With the pointer in
  // 0x4000..0x7FFF the flat address is simply the bank above the low 14 pointer bits.
  logic [AW-1:0]              flat;
  logic                       ptr_ok;
  logic                       bound_ok;
  logic                       cand;

  assign ptr_ok   = (win_q[6][7:6] == dss_pkg::PTR_PAGE);
  assign flat     = {win_q[11], win_q[6][5:0], win_q[5]};
  assign bound_ok = ({2'b00, flat} + dss_pkg::FLAT_GUARD) <= size_r;
  assign cand     = in_fire && scan_zone && sig_ok && ptr_ok && bound_ok;

  // ---------------------------------------------------------------------------
  // Hit-table chain: a new address enters cell 0 and every entry moves one cell on,
  // so cells 0..count-1 are valid. All cells compare against the candidate at once.
  // ---------------------------------------------------------------------------
  dss_pkg::cell_ctl_t          tab_ctl;
  logic [HIT_TABLE_DEPTH-1:0]  tab_v;
  logic [AW-1:0]               tab_a   [HIT_TABLE_DEPTH];
  logic [HIT_TABLE_DEPTH-1:0]  tab_vin;
  logic [AW-1:0]               tab_ain [HIT_TABLE_DEPTH];
  logic [HIT_TABLE_DEPTH-1:0]  tab_match;
  logic                        dup;
  logic                        full;
  logic                        hit;
  logic                        store;

  assign dup   = |tab_match;
  assign full  = tab_v[HIT_TABLE_DEPTH-1];
  assign hit   = cand && !dup;
  assign store = hit && !full;

  assign tab_ctl.clear = in_fire && last_byte;
  assign tab_ctl.shift = store;

  for (genvar k = 0; k < HIT_TABLE_DEPTH; k++) begin : g_tab
    if (k == 0) begin : g_head
      assign tab_vin[k] = 1'b1;
      assign tab_ain[k] = flat;
    end else begin : g_body
      assign tab_vin[k] = tab_v[k-1];
      assign tab_ain[k] = tab_a[k-1];
    end
    dss_hit_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (tab_ctl),
      .v_in  (tab_vin[k]),
      .a_in  (tab_ain[k]),
      .probe (flat),
      .v_out (tab_v[k]),
      .a_out (tab_a[k]),
      .match (tab_match[k])
    );
  end

  // Distinct-hit count and sticky overflow, both cleared on rearm.
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             ovf_r;
  logic             ovf_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (in_fire && last_byte) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (store) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (hit) begin
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result forming. The last byte never coincides with a hit, since a checked
  // window must end before the last byte.
  // ---------------------------------------------------------------------------
  dss_pkg::res_t res;
  logic          res_valid;

  always_comb begin
    res.kind  = dss_pkg::KIND_HIT;
    res.addr  = flat;
    res.bank  = win_q[11];
    res.count = dss_pkg::CNT_OUT_W'(store ? cnt_r + CNT_W'(1) : cnt_r);
    res.ovf   = !store;
    if (last_byte) begin
      res.kind  = dss_pkg::KIND_SUMMARY;
      res.addr  = '0;
      res.bank  = '0;
      res.count = dss_pkg::CNT_OUT_W'(cnt_r);
      res.ovf   = ovf_r;
    end
  end

  assign res_valid = in_fire && (hit || last_byte);

  // ---------------------------------------------------------------------------
  // Output register plus skid entry: the input stays open while one result waits.
  // ---------------------------------------------------------------------------
  dss_pkg::res_t out_r;
  dss_pkg::res_t out_nxt;
  dss_pkg::res_t skid_r;
  dss_pkg::res_t skid_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic          skid_valid_r;
  logic          skid_valid_nxt;

  assign in_tready = !skid_valid_r;

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt  = skid_valid_r;
      out_nxt        = skid_r;
      skid_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_nxt       = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {2'b00, out_r.ovf, out_r.count, out_r.bank, out_r.addr};

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tab_v) == int'(cnt_r))
    else $error("hit count disagrees with valid table cells");

  a_no_double_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tab_match))
    else $error("address stored in more than one table cell");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_byte) |=> (pos_r == '0 && cnt_r == '0 && !ovf_r && tab_v == '0))
    else $error("scan state not rearmed after the last byte");

  a_summary_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_byte) |-> !hit)
    else $error("hit coincides with end of image");

endmodule

`default_nettype wire
